### design/square_matrix_add_sub_multiply_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the square matrix unit
// Implication and next-cycle checks, clocked on the rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_ADD_SUB_MULTIPLY_ASSERT_SVH
`define SQUARE_MATRIX_ADD_SUB_MULTIPLY_ASSERT_SVH

// same-cycle implication
`define SQM_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SQM_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

### design/sqm_pkg.sv
// ----------------------------------------------------------------------------
// sqm_pkg
// Shared types and constants for the square matrix add, subtract, multiply unit.
// ----------------------------------------------------------------------------
package sqm_pkg;

  localparam int MAX_DIM_DEF = 16;
  localparam int DATA_W      = 32;
  localparam int IDX_IN_W    = 4;
  localparam int CMD_W       = 2;
  localparam int MSIZE_W     = 5;
  localparam int OPM_W       = 2;
  localparam int IN_TDATA_W  = 2 * IDX_IN_W + DATA_W;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 5;

  localparam logic [MSIZE_W-1:0] MSIZE_RST = MSIZE_W'(16);

  localparam logic [CFG_IDX_W-1:0] CFG_MAT_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE  = CFG_IDX_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_A = 2'd0,
    CMD_WR_B = 2'd1,
    CMD_RD   = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [OPM_W-1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_MUL  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic push;
  } ctl_cmd_t;

  typedef struct packed {
    logic compute;
    logic last;
    logic busy;
    logic out_free;
  } ctl_sts_t;

endpackage

### design/sqm_ctrl.sv
// ----------------------------------------------------------------------------
// sqm_ctrl
// Sequencer: take one item, walk the read/accumulate steps for a read, hand off the result.
// ----------------------------------------------------------------------------
module sqm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  sqm_pkg::ctl_sts_t sts,
  output sqm_pkg::ctl_cmd_t cmd
);
  import sqm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = sts.compute ? ST_ISSUE : ST_DONE;
        end
      end
      ST_ISSUE: begin
        if (sts.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load      = s_axis_tvalid;
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_DONE: begin
        cmd.push = sts.out_free;
      end
    endcase
  end

endmodule

### design/sqm_datapath.sv
// ----------------------------------------------------------------------------
// sqm_datapath
// Element stores, read/combine/accumulate pipeline and result register.
// ----------------------------------------------------------------------------
module sqm_datapath #(
  parameter int MAX_DIM = sqm_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sqm_pkg::ctl_cmd_t               cmd,
  output sqm_pkg::ctl_sts_t               sts,
  input  logic [sqm_pkg::MSIZE_W-1:0]     mat_size,
  input  logic [sqm_pkg::OPM_W-1:0]       op_mode,
  input  logic [sqm_pkg::CMD_W-1:0]       s_axis_tuser,
  input  logic [sqm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sqm_pkg::DATA_W-1:0]      m_axis_tdata,
  output logic                            m_axis_tuser
);
  import sqm_pkg::*;

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW     = $clog2(MAX_DIM + 1);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [DIM_W-1:0] r,
                                                 input logic [DIM_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  logic [DATA_W-1:0] a_mem [DEPTH];
  logic [DATA_W-1:0] b_mem [DEPTH];

  logic [NW-1:0]       n_used;
  cmd_t                in_cmd;
  logic [IDX_IN_W-1:0] in_row;
  logic [IDX_IN_W-1:0] in_col;
  logic [DATA_W-1:0]   in_val;
  logic                in_bad;
  logic [ADDR_W-1:0]   wr_addr;

  logic [DIM_W-1:0]  row_q;
  logic [DIM_W-1:0]  col_q;
  logic [DIM_W-1:0]  k;
  logic              err_q;
  logic              rd_q;
  logic              mul;
  op_t               op;
  logic [ADDR_W-1:0] ra;
  logic [ADDR_W-1:0] rb;

  logic [DATA_W-1:0] a_q;
  logic [DATA_W-1:0] b_q;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] acc;
  logic              v1;
  logic              v2;

  assign n_used  = (int'(mat_size) > MAX_DIM) ? NW'(MAX_DIM) : NW'(mat_size);
  assign in_cmd  = cmd_t'(s_axis_tuser);
  assign in_row  = s_axis_tdata[IDX_IN_W-1:0];
  assign in_col  = s_axis_tdata[2*IDX_IN_W-1:IDX_IN_W];
  assign in_val  = s_axis_tdata[IN_TDATA_W-1:2*IDX_IN_W];
  assign in_bad  = (int'(in_row) >= int'(n_used)) || (int'(in_col) >= int'(n_used));
  assign wr_addr = addr_of(DIM_W'(in_row), DIM_W'(in_col));

  assign op  = op_t'(op_mode);
  assign mul = (op == OP_MUL);
  assign ra  = mul ? addr_of(row_q, k) : addr_of(row_q, col_q);
  assign rb  = mul ? addr_of(k, col_q) : addr_of(row_q, col_q);

  assign sts.compute  = (in_cmd == CMD_RD) && !in_bad;
  assign sts.last     = !mul || (int'(k) == int'(n_used) - 1);
  assign sts.busy     = v1 || v2;
  assign sts.out_free = !m_axis_tvalid || m_axis_tready;

  // stores: one write port at accept, one registered read port per step
  always_ff @(posedge clk) begin
    if (cmd.load && !in_bad && (in_cmd == CMD_WR_A)) begin
      a_mem[wr_addr] <= in_val;
    end
    if (cmd.issue) begin
      a_q <= a_mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !in_bad && (in_cmd == CMD_WR_B)) begin
      b_mem[wr_addr] <= in_val;
    end
    if (cmd.issue) begin
      b_q <= b_mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_q <= DIM_W'(in_row);
      col_q <= DIM_W'(in_col);
      err_q <= (in_cmd != CMD_NOP) && in_bad;
      rd_q  <= (in_cmd == CMD_RD) && !in_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.load) begin
      k <= '0;
    end else if (cmd.issue) begin
      k <= k + DIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      unique case (op)
        OP_ADD:  prod <= a_q + b_q;
        OP_SUB:  prod <= a_q - b_q;
        OP_MUL:  prod <= DATA_W'(a_q * b_q);
        OP_NONE: prod <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + prod;
    end
  end

  // result register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      m_axis_tdata <= rd_q ? acc : '0;
      m_axis_tuser <= err_q;
    end
  end

endmodule

### design/square_matrix_add_sub_multiply.sv
// ----------------------------------------------------------------------------
// square_matrix_add_sub_multiply
// Two square integer matrices in stores; element writes and result reads
// (A+B, A-B or A*B) with 32-bit wrapping arithmetic.
//
//   channel   direction  content
//   s_axis    in         tuser: cmd; tdata: row, col, elem_value
//   m_axis    out        tuser: range_error; tdata: result_value
//   cfg       in         cfg_index, cfg_data (mat_size, op_mode)
//
// Write, out-of-range or unused command: straight from idle to the result hand-off.
// Add or subtract read: one read step, drain, hand-off. Multiply read: one step per
// used index, one product per cycle through the single read port of each store.
// Reset clears control, mat_size to 16, op_mode to multiply; stores not cleared.
// Input is taken only when idle; a result waiting on m_axis holds the block.
// ----------------------------------------------------------------------------
`include "square_matrix_add_sub_multiply_assert.svh"

module square_matrix_add_sub_multiply #(
  parameter int MAX_DIM = sqm_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sqm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // row[3:0], col[7:4], elem_value[39:8]
  input  logic [sqm_pkg::CMD_W-1:0]       s_axis_tuser,  // cmd[1:0]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sqm_pkg::DATA_W-1:0]      m_axis_tdata,  // result_value[31:0]
  output logic                            m_axis_tuser,  // range_error[0]
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sqm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sqm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sqm_pkg::*;

  logic [MSIZE_W-1:0] mat_size;
  logic [OPM_W-1:0]   op_mode;
  ctl_cmd_t           cmd;
  ctl_sts_t           sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_size <= MSIZE_RST;
      op_mode  <= OP_MUL;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_MAT_SIZE) begin
        mat_size <= cfg_data[MSIZE_W-1:0];
      end
      if (cfg_index == CFG_OP_MODE) begin
        op_mode <= cfg_data[OPM_W-1:0];
      end
    end
  end

  sqm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts           (sts),
    .cmd           (cmd)
  );

  sqm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .mat_size      (mat_size),
    .op_mode       (op_mode),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  `SQM_ASSERT_NOW(a_idle_drained, clk, rst, s_axis_tready, !sts.busy, "input taken while pipeline busy")
  `SQM_ASSERT_NEXT(a_issue_run, clk, rst, cmd.issue && !sts.last, cmd.issue, "issue run cut short")
  `SQM_ASSERT_NEXT(a_out_clear, clk, rst, m_axis_tvalid && m_axis_tready && !cmd.push, !m_axis_tvalid, "beat repeated")

endmodule
